FILE: design/dirs_pkg.sv
// Shared types, constants and helpers for the disk image record scanner.
// No dependencies; every other design file imports this package.
package dirs_pkg;

  // Fixed file header length in bytes (valid range 16 to 255)
  localparam int FILE_HEADER_BYTES = 128;
  // Record header length and derived index width
  localparam int REC_HEADER_LEN = 16;
  localparam int HDR_IDX_W      = $clog2(REC_HEADER_LEN);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Configuration register indexes (paddr[3:2])
  localparam logic [1:0] REG_SECTOR_TYPE  = 2'd0;
  localparam logic [1:0] REG_DELETED_TYPE = 2'd1;
  localparam logic [1:0] REG_FILL_CODE    = 2'd2;

  localparam logic [31:0] SECTOR_TYPE_RST  = 32'hE31D_0001;
  localparam logic [31:0] DELETED_TYPE_RST = 32'hE31D_0000;
  localparam logic [15:0] FILL_CODE_RST    = 16'h3E5A;

  // Parser phase
  typedef enum logic [2:0] {
    PH_FILE_HEADER = 3'd0,
    PH_GATHER      = 3'd1,
    PH_EXTRA       = 3'd2,
    PH_DATA        = 3'd3,
    PH_STOPPED     = 3'd4
  } phase_t;

  // Input request
  typedef struct packed {
    logic [7:0] file_byte;
    logic       final_byte;
  } in_t;

  // Summary result
  typedef struct packed {
    logic        status;
    logic [15:0] top_cylinder;
    logic [7:0]  top_head;
    logic [7:0]  top_sector;
    logic [31:0] sector_records;
    logic [31:0] deleted_records;
    logic [31:0] fill_records;
  } out_t;

  // Configuration register values
  typedef struct packed {
    logic [31:0] sector_type;
    logic [31:0] deleted_type;
    logic [15:0] fill_code;
  } cfg_t;

  // Classified event handed from front to back
  typedef struct packed {
    logic        counted;     // finished sector or deleted record
    logic        deleted;
    logic        fill;
    logic [15:0] cyl;
    logic [7:0]  head;
    logic [7:0]  sect;
    logic        last;        // final byte of the file: emit summary
    logic        short_file;  // file ended inside the file header
  } rec_t;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

FILE: design/dirs_front.sv
// Front end: accepts file bytes, walks the record structure and classifies
// finished record headers. Depends on dirs_pkg.
module dirs_front (
  input  logic           clk,
  input  logic           rst_n,
  input  dirs_pkg::in_t  in_data,
  input  logic           in_valid,
  output logic           in_ready,
  input  dirs_pkg::cfg_t cfg,
  input  logic           q_full,
  output logic           q_push,
  output dirs_pkg::rec_t q_data
);
  import dirs_pkg::*;

  localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(REC_HEADER_LEN - 1);

  phase_t               phase_r, phase_step, phase_nxt;
  logic [7:0]           fh_cnt_r, fh_cnt_nxt;
  logic [HDR_IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]          extra_r, extra_nxt, extra_calc;
  logic [31:0]          data_r, data_nxt;
  logic [7:0]           hdr_r [REC_HEADER_LEN];
  logic [7:0]           hv [REC_HEADER_LEN];
  logic                 accept, finish, counted;
  logic [31:0]          rec_type, rec_size;
  logic [15:0]          rec_comp, hsize;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Header view: last byte comes straight from the input while gathering
  always_comb begin
    for (int i = 0; i < REC_HEADER_LEN; i++) begin
      hv[i] = hdr_r[i];
    end
    if (phase_r == PH_GATHER) begin
      hv[REC_HEADER_LEN-1] = in_data.file_byte;
    end
  end

  assign rec_type   = {hv[3], hv[2], hv[1], hv[0]};
  assign rec_comp   = {hv[5], hv[4]};
  assign hsize      = {hv[7], hv[6]};
  assign rec_size   = {hv[11], hv[10], hv[9], hv[8]};
  assign extra_calc = hsize - 16'(REC_HEADER_LEN);

  // Next state
  always_comb begin
    phase_step = phase_r;
    fh_cnt_nxt = fh_cnt_r;
    idx_nxt    = idx_r;
    extra_nxt  = extra_r;
    data_nxt   = data_r;
    finish     = 1'b0;
    if (accept) begin
      unique case (phase_r)
        PH_FILE_HEADER: begin
          fh_cnt_nxt = fh_cnt_r + 8'd1;
          if (fh_cnt_nxt >= 8'(FILE_HEADER_BYTES)) begin
            phase_step = PH_GATHER;
          end
        end
        PH_GATHER: begin
          if (idx_r == HDR_LAST) begin
            idx_nxt = '0;
            if (hsize < 16'(REC_HEADER_LEN)) begin
              phase_step = PH_STOPPED;
            end else if (extra_calc == 16'd0) begin
              finish = 1'b1;
            end else begin
              extra_nxt  = extra_calc;
              phase_step = PH_EXTRA;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        PH_EXTRA: begin
          extra_nxt = extra_r - 16'd1;
          if (extra_nxt == 16'd0) begin
            finish = 1'b1;
          end
        end
        PH_DATA: begin
          data_nxt = data_r - 32'd1;
          if (data_nxt == 32'd0) begin
            phase_step = PH_GATHER;
          end
        end
        PH_STOPPED: ;
        default: phase_step = PH_STOPPED;
      endcase
      if (finish) begin
        data_nxt   = rec_size;
        phase_step = (rec_size != 32'd0) ? PH_DATA : PH_GATHER;
      end
    end
    phase_nxt = (accept && in_data.final_byte) ? PH_FILE_HEADER : phase_step;
  end

  // Outputs toward the queue
  always_comb begin
    counted           = (rec_type == cfg.sector_type) || (rec_type == cfg.deleted_type);
    q_push            = accept && ((finish && counted) || in_data.final_byte);
    q_data.counted    = finish && counted;
    q_data.deleted    = rec_type == cfg.deleted_type;
    q_data.fill       = rec_comp == cfg.fill_code;
    q_data.cyl        = {hv[15], hv[14]};
    q_data.head       = hv[12];
    q_data.sect       = hv[13];
    q_data.last       = in_data.final_byte;
    q_data.short_file = phase_step == PH_FILE_HEADER;
  end

  // Control state; the final byte returns everything to reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FILE_HEADER;
      fh_cnt_r <= '0;
      idx_r    <= '0;
      extra_r  <= '0;
      data_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      if (accept && in_data.final_byte) begin
        fh_cnt_r <= '0;
        idx_r    <= '0;
        extra_r  <= '0;
        data_r   <= '0;
      end else begin
        fh_cnt_r <= fh_cnt_nxt;
        idx_r    <= idx_nxt;
        extra_r  <= extra_nxt;
        data_r   <= data_nxt;
      end
    end
  end

  // Record header bytes
  always_ff @(posedge clk) begin
    if (accept && phase_r == PH_GATHER) begin
      hdr_r[idx_r] <= in_data.file_byte;
    end
  end

  a_idx_only_gather: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_GATHER |-> idx_r == '0)
    else $error("header index nonzero outside gathering");
  a_extra_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_EXTRA |-> extra_r != 16'd0)
    else $error("extra header phase with nothing left");
  a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.final_byte) |=> (phase_r == PH_FILE_HEADER && fh_cnt_r == 8'd0))
    else $error("scan not restarted after final byte");

endmodule

FILE: design/dirs_queue.sv
// Small flop queue that decouples the byte parser from the accumulator.
// Depends on dirs_pkg.
module dirs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dirs_pkg::rec_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output dirs_pkg::rec_t pop_data
);
  import dirs_pkg::*;

  rec_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   cnt_r, cnt_nxt;

  assign full      = cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign pop_valid = cnt_r != '0;
  assign pop_data  = mem_r[rd_ptr_r];

  // Occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("queue pop while empty");

endmodule

FILE: design/dirs_back.sv
// Back end: accumulates peaks and saturating counts from classified records
// and emits the summary into an output register. Depends on dirs_pkg.
module dirs_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  dirs_pkg::rec_t q_data,
  output logic           q_pop,
  output dirs_pkg::out_t out_data,
  output logic           out_valid,
  input  logic           out_ready
);
  import dirs_pkg::*;

  logic [15:0] pk_cyl_r, cyl_upd;
  logic [7:0]  pk_head_r, head_upd;
  logic [7:0]  pk_sect_r, sect_upd;
  logic [31:0] tot_r, tot_upd;
  logic [31:0] del_r, del_upd;
  logic [31:0] fill_r, fill_upd;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_r, summary;

  // Summary entries wait for a free output register
  assign q_pop     = q_valid && (!q_data.last || !out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Accumulator update for one record
  always_comb begin
    cyl_upd  = pk_cyl_r;
    head_upd = pk_head_r;
    sect_upd = pk_sect_r;
    tot_upd  = tot_r;
    del_upd  = del_r;
    fill_upd = fill_r;
    if (q_data.counted) begin
      if (q_data.cyl > pk_cyl_r) cyl_upd = q_data.cyl;
      if (q_data.head > pk_head_r) head_upd = q_data.head;
      if (q_data.sect > pk_sect_r) sect_upd = q_data.sect;
      tot_upd = sat_inc(tot_r);
      if (q_data.deleted) del_upd = sat_inc(del_r);
      if (q_data.fill) fill_upd = sat_inc(fill_r);
    end
  end

  // Summary word; a short file reports only the status flag
  always_comb begin
    summary.status          = q_data.short_file;
    summary.top_cylinder    = q_data.short_file ? '0 : cyl_upd;
    summary.top_head        = q_data.short_file ? '0 : head_upd;
    summary.top_sector      = q_data.short_file ? '0 : sect_upd;
    summary.sector_records  = q_data.short_file ? '0 : tot_upd;
    summary.deleted_records = q_data.short_file ? '0 : del_upd;
    summary.fill_records    = q_data.short_file ? '0 : fill_upd;
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (q_pop && q_data.last) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pk_cyl_r    <= '0;
      pk_head_r   <= '0;
      pk_sect_r   <= '0;
      tot_r       <= '0;
      del_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        if (q_data.last) begin
          pk_cyl_r  <= '0;
          pk_head_r <= '0;
          pk_sect_r <= '0;
          tot_r     <= '0;
          del_r     <= '0;
          fill_r    <= '0;
        end else begin
          pk_cyl_r  <= cyl_upd;
          pk_head_r <= head_upd;
          pk_sect_r <= sect_upd;
          tot_r     <= tot_upd;
          del_r     <= del_upd;
          fill_r    <= fill_upd;
        end
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (q_pop && q_data.last) begin
      out_r <= summary;
    end
  end

endmodule

FILE: design/disk_image_record_scanner.sv
// Disk image record scanner: takes an image file one byte per cycle on the
// in_ channel, skips the file header, parses each record header and emits one
// summary request on the out_ channel for the byte marked final. Sustained
// rate is one byte per clock; the front parser stalls only when its 4-entry
// event queue is full, which happens only while the output register holds an
// untaken summary. With the queue empty, the final byte's event is registered
// in the queue, then popped into the output register, raising out_valid.
// Type and compression codes are set over the APB port (0x0 sector type, 0x4
// deleted type, 0x8 fill code) while idle, which the block leaves to the user.
// Depends on dirs_pkg, dirs_front, dirs_queue and dirs_back.
module disk_image_record_scanner (
  input  logic           clk,
  input  logic           rst_n,
  input  dirs_pkg::in_t  in_data,
  input  logic           in_valid,
  output logic           in_ready,
  output dirs_pkg::out_t out_data,
  output logic           out_valid,
  input  logic           out_ready,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import dirs_pkg::*;

  cfg_t       cfg_r;
  logic [1:0] reg_idx;
  logic       q_push, q_full, q_pop, q_valid;
  rec_t       q_in, q_out;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sector_type  <= SECTOR_TYPE_RST;
      cfg_r.deleted_type <= DELETED_TYPE_RST;
      cfg_r.fill_code    <= FILL_CODE_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_SECTOR_TYPE:  cfg_r.sector_type  <= pwdata;
        REG_DELETED_TYPE: cfg_r.deleted_type <= pwdata;
        REG_FILL_CODE:    cfg_r.fill_code    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      REG_SECTOR_TYPE:  prdata = cfg_r.sector_type;
      REG_DELETED_TYPE: prdata = cfg_r.deleted_type;
      REG_FILL_CODE:    prdata = {16'd0, cfg_r.fill_code};
      default:          prdata = '0;
    endcase
  end

  dirs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  dirs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_out)
  );

  dirs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule
